[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers included by the RTL file that carries checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, held off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed: check the controller sequencing");

// Check a property on every rising edge, reset included.
`define ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed: check the reset sequencing");

`endif

[rtl/lcdfb_pkg.sv]
// ----------------------------------------------------------------------------
// lcdfb_pkg
// Panel geometry, register offsets, codes and control types shared by the
// monochrome LCD frame store controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdfb_pkg;

  localparam int PANEL_WIDTH   = 320;
  localparam int PANEL_HEIGHT  = 240;
  localparam int REFRESH_DELAY = 500;

  localparam int FRAME_BYTES   = (PANEL_WIDTH * PANEL_HEIGHT) / 8;
  localparam int ROW_BYTES     = PANEL_WIDTH / 8;
  localparam int FRAME_AW      = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

  localparam int SCRATCH_COUNT = 64;
  localparam int SCRATCH_AW    = 6;

  // Sweep covers the frame store and the scratch registers together.
  localparam int CLEAR_COUNT   = (FRAME_BYTES > SCRATCH_COUNT) ? FRAME_BYTES : SCRATCH_COUNT;
  localparam int CLEAR_AW      = $clog2(CLEAR_COUNT);

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [7:0] ADDR_STATUS      = 8'h00;
  localparam logic [7:0] ADDR_DATA_READ   = 8'h08;
  localparam logic [7:0] ADDR_POWER       = 8'h44;
  localparam logic [7:0] ADDR_DATA_WRITE  = 8'h48;
  localparam logic [7:0] ADDR_CURSOR_HIGH = 8'h4c;
  localparam logic [7:0] ADDR_CURSOR_LOW  = 8'h50;
  localparam logic [7:0] ADDR_MODE        = 8'h54;

  localparam logic [7:0] MODE_ROW_BACK = 8'hd8;
  localparam logic [7:0] MODE_FORWARD  = 8'h01;
  localparam logic [7:0] STATUS_VALUE  = 8'h20;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic clear_en;
    logic accept;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/mono_lcd_cursor_framebuffer_regs.sv]
// ----------------------------------------------------------------------------
// mono_lcd_cursor_framebuffer_regs: 320x240 monochrome LCD frame store
// Flow: the frame store read is registered on acceptance, ahead of the commit;
// no new word is taken until the commit, which waits for a free result slot.
// Reset: a clearing sweep zeroes frame store and scratch first.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mono_lcd_cursor_framebuffer_regs (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] operation,
  input  wire logic [7:0] address,
  input  wire logic [7:0] write_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [7:0] read_data,
  output logic            refresh,
  output logic            display_powered
);

  lcdfb_pkg::ctrl_cmd_t  cmd;
  lcdfb_pkg::dp_status_t status;

  lcdfb_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  lcdfb_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .operation       (operation),
    .address         (address),
    .write_data      (write_data),
    .read_data       (read_data),
    .refresh         (refresh),
    .display_powered (display_powered)
  );

  // one word in flight: no second acceptance straight after the first
  `ASSERT_CLK_RST(a_single_word, clk, rst, (in_valid && in_ready) |=> !in_ready)
  // a result only appears out of the commit cycle, never from idle
  `ASSERT_CLK_RST(a_result_from_commit, clk, rst, $rose(out_valid) |-> $past(!in_ready))
  // the clearing sweep runs before any word is taken
  `ASSERT_CLK(a_clear_after_reset, clk, $past(rst) |-> !in_ready)

endmodule

`default_nettype wire

[rtl/lcdfb_controller.sv]
// ----------------------------------------------------------------------------
// lcdfb_controller
// Sequences the clearing sweep after reset, then one word at a time through
// a read on acceptance and a stallable commit; owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdfb_controller (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  input  wire lcdfb_pkg::dp_status_t status,
  output lcdfb_pkg::ctrl_cmd_t       cmd
);

  lcdfb_pkg::state_t state;
  lcdfb_pkg::state_t state_next;
  logic              slot_free;

  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      lcdfb_pkg::ST_CLEAR: begin
        if (status.clear_last) state_next = lcdfb_pkg::ST_IDLE;
      end
      lcdfb_pkg::ST_IDLE: begin
        if (in_valid) state_next = lcdfb_pkg::ST_EXEC;
      end
      lcdfb_pkg::ST_EXEC: begin
        // hold until the result register can take the word
        if (slot_free) state_next = lcdfb_pkg::ST_IDLE;
      end
      default: state_next = lcdfb_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready     = (state == lcdfb_pkg::ST_IDLE);
    cmd.clear_en = (state == lcdfb_pkg::ST_CLEAR);
    cmd.accept   = (state == lcdfb_pkg::ST_IDLE) && in_valid;
    cmd.commit   = (state == lcdfb_pkg::ST_EXEC) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lcdfb_pkg::ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/lcdfb_datapath.sv]
// ----------------------------------------------------------------------------
// lcdfb_datapath
// Frame store, scratch registers, cursor, mode, refresh timer and the result
// register, driven by the controller's commands.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdfb_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire lcdfb_pkg::ctrl_cmd_t cmd,
  output lcdfb_pkg::dp_status_t     status,
  input  wire logic [1:0]           operation,
  input  wire logic [7:0]           address,
  input  wire logic [7:0]           write_data,
  output logic      [7:0]           read_data,
  output logic                      refresh,
  output logic                      display_powered
);

  localparam int FAW = lcdfb_pkg::FRAME_AW;
  localparam int SAW = lcdfb_pkg::SCRATCH_AW;
  localparam int CAW = lcdfb_pkg::CLEAR_AW;

  logic [7:0] frame_mem   [lcdfb_pkg::FRAME_BYTES];
  logic [7:0] scratch_mem [lcdfb_pkg::SCRATCH_COUNT];

  logic [CAW-1:0] clear_addr;
  logic [1:0]     item_op;
  logic [7:0]     item_addr;
  logic [7:0]     item_data;
  logic [7:0]     frame_rd;
  logic [7:0]     scratch_rd;

  logic [15:0] cursor;
  logic [15:0] cursor_next;
  logic [7:0]  mode;
  logic [7:0]  mode_next;
  logic        dirty;
  logic        dirty_next;
  logic [8:0]  ticks;
  logic [8:0]  ticks_next;
  logic [8:0]  ticks_inc;
  logic        powered;
  logic        powered_next;
  logic [7:0]  rd_next;
  logic        refresh_next;

  logic [FAW-1:0] eff_idx;
  logic           frame_we;
  logic [FAW-1:0] frame_waddr;
  logic [7:0]     frame_wdata;
  logic           scratch_we;
  logic [SAW-1:0] scratch_waddr;
  logic [7:0]     scratch_wdata;
  logic           is_data_write;

  assign status.clear_last = (32'(clear_addr) == lcdfb_pkg::CLEAR_COUNT - 1);

  // out-of-range cursor addresses byte zero
  assign eff_idx = (32'(cursor) >= lcdfb_pkg::FRAME_BYTES) ? '0 : FAW'(cursor);

  assign is_data_write = (item_op == lcdfb_pkg::OP_WRITE) &&
                         (item_addr == lcdfb_pkg::ADDR_DATA_WRITE);

  always_comb begin
    if (cmd.clear_en) begin
      frame_we      = (32'(clear_addr) < lcdfb_pkg::FRAME_BYTES);
      frame_waddr   = FAW'(clear_addr);
      frame_wdata   = 8'h00;
      scratch_we    = 1'b1;
      scratch_waddr = clear_addr[SAW-1:0];
      scratch_wdata = 8'h00;
    end else begin
      frame_we      = cmd.commit && is_data_write;
      frame_waddr   = eff_idx;
      frame_wdata   = item_data;
      scratch_we    = cmd.commit && (item_op == lcdfb_pkg::OP_WRITE);
      scratch_waddr = item_addr[7:2];
      scratch_wdata = item_data;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_we) frame_mem[frame_waddr] <= frame_wdata;
    if (cmd.accept) frame_rd <= frame_mem[eff_idx];
  end

  always_ff @(posedge clk) begin
    if (scratch_we) scratch_mem[scratch_waddr] <= scratch_wdata;
    if (cmd.accept) scratch_rd <= scratch_mem[address[7:2]];
  end

  assign ticks_inc = ticks + 9'd1;

  always_comb begin
    cursor_next  = cursor;
    mode_next    = mode;
    dirty_next   = dirty;
    ticks_next   = ticks;
    powered_next = powered;
    rd_next      = 8'h00;
    refresh_next = 1'b0;
    unique case (item_op)
      lcdfb_pkg::OP_READ: begin
        unique case (item_addr)
          lcdfb_pkg::ADDR_STATUS:      rd_next = lcdfb_pkg::STATUS_VALUE;
          lcdfb_pkg::ADDR_DATA_READ:   rd_next = frame_rd;
          lcdfb_pkg::ADDR_CURSOR_HIGH: rd_next = cursor[15:8];
          lcdfb_pkg::ADDR_CURSOR_LOW:  rd_next = cursor[7:0];
          lcdfb_pkg::ADDR_MODE:        rd_next = mode;
          default:                     rd_next = scratch_rd;
        endcase
      end
      lcdfb_pkg::OP_WRITE: begin
        unique case (item_addr)
          lcdfb_pkg::ADDR_CURSOR_HIGH: cursor_next = {item_data, cursor[7:0]};
          lcdfb_pkg::ADDR_CURSOR_LOW:  cursor_next = {cursor[15:8], item_data};
          lcdfb_pkg::ADDR_MODE:        mode_next   = item_data;
          lcdfb_pkg::ADDR_POWER: begin
            // compare against the byte held before this write
            if (scratch_rd != item_data) begin
              powered_next = (item_data != 8'h00);
              dirty_next   = 1'b0;
              ticks_next   = '0;
              refresh_next = 1'b1;
            end
          end
          lcdfb_pkg::ADDR_DATA_WRITE: begin
            priority if (mode == lcdfb_pkg::MODE_ROW_BACK) begin
              cursor_next = cursor - 16'(lcdfb_pkg::ROW_BYTES);
            end else if (mode == lcdfb_pkg::MODE_FORWARD) begin
              cursor_next = cursor + 16'd1;
            end else begin
              cursor_next = cursor;
            end
            dirty_next = 1'b1;
            ticks_next = '0;
          end
          default: begin
            cursor_next = cursor;
          end
        endcase
      end
      lcdfb_pkg::OP_TICK: begin
        if (dirty) begin
          ticks_next = ticks_inc;
          if (ticks_inc >= 9'(lcdfb_pkg::REFRESH_DELAY)) begin
            dirty_next   = 1'b0;
            ticks_next   = '0;
            refresh_next = 1'b1;
          end
        end
      end
      default: begin
        rd_next = 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
      cursor     <= '0;
      mode       <= '0;
      dirty      <= 1'b0;
      ticks      <= '0;
      powered    <= 1'b0;
    end else begin
      if (cmd.clear_en && !status.clear_last) clear_addr <= clear_addr + 1'b1;
      if (cmd.commit) begin
        cursor  <= cursor_next;
        mode    <= mode_next;
        dirty   <= dirty_next;
        ticks   <= ticks_next;
        powered <= powered_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_op   <= operation;
      item_addr <= address;
      item_data <= write_data;
    end
    if (cmd.commit) begin
      read_data       <= rd_next;
      refresh         <= refresh_next;
      display_powered <= powered_next;
    end
  end

endmodule

`default_nettype wire

[tb/mono_lcd_cursor_framebuffer_regs_tb.sv]
// ----------------------------------------------------------------------------
// mono_lcd_cursor_framebuffer_regs_tb
// Drives bus reads, bus writes and ticks into the LCD frame store controller
// and checks every result word against a shadow copy of the cursor, mode,
// scratch bytes, frame store and refresh timer kept inside a scoreboard.
// ----------------------------------------------------------------------------
`default_nettype none

module mono_lcd_cursor_framebuffer_regs_tb;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam int         WATCHDOG_LIMIT = 40000;
  localparam int         MIXED_PER_PHASE = 45;

  typedef struct {
    logic [7:0] rd_byte;
    logic       refresh_req;
    logic       powered;
  } lcd_result_t;

  // Shadow of the controller state; predicts one result word per bus word.
  class lcd_reg_scoreboard;
    bit [15:0]   cursor;
    bit [7:0]    mode;
    bit [7:0]    scratch [lcdfb_pkg::SCRATCH_COUNT];
    bit [7:0]    frame [lcdfb_pkg::FRAME_BYTES];
    bit          dirty;
    bit [8:0]    ticks;
    bit          powered;
    lcd_result_t expected_words [$];
    int          mismatches;
    int          words_checked;
    int          refreshes;
    int          tick_refreshes;
    int          edge_accesses;

    function int unsigned frame_index();
      if (cursor >= lcdfb_pkg::FRAME_BYTES) begin
        edge_accesses++;
        return 0;
      end
      return 32'(cursor);
    endfunction

    function void note_word(logic [1:0] op, logic [7:0] addr, logic [7:0] data);
      lcd_result_t r;
      int unsigned slot;
      r.rd_byte     = 8'h00;
      r.refresh_req = 1'b0;
      slot          = 32'(addr >> 2);
      case (op)
        lcdfb_pkg::OP_READ: begin
          case (addr)
            lcdfb_pkg::ADDR_STATUS:      r.rd_byte = lcdfb_pkg::STATUS_VALUE;
            lcdfb_pkg::ADDR_DATA_READ:   r.rd_byte = frame[frame_index()];
            lcdfb_pkg::ADDR_CURSOR_HIGH: r.rd_byte = cursor[15:8];
            lcdfb_pkg::ADDR_CURSOR_LOW:  r.rd_byte = cursor[7:0];
            lcdfb_pkg::ADDR_MODE:        r.rd_byte = mode;
            default:                     r.rd_byte = scratch[slot];
          endcase
        end
        lcdfb_pkg::OP_WRITE: begin
          case (addr)
            lcdfb_pkg::ADDR_CURSOR_HIGH: cursor[15:8] = data;
            lcdfb_pkg::ADDR_CURSOR_LOW:  cursor[7:0] = data;
            lcdfb_pkg::ADDR_MODE:        mode = data;
            lcdfb_pkg::ADDR_POWER: begin
              // compare against the byte already held, not the live flag
              if (scratch[slot] != data) begin
                powered       = (data != 8'h00);
                dirty         = 1'b0;
                ticks         = '0;
                r.refresh_req = 1'b1;
              end
            end
            lcdfb_pkg::ADDR_DATA_WRITE: begin
              frame[frame_index()] = data;
              // step from the cursor as written, not the remapped byte
              if (mode == lcdfb_pkg::MODE_ROW_BACK)
                cursor = cursor - 16'(lcdfb_pkg::ROW_BYTES);
              else if (mode == lcdfb_pkg::MODE_FORWARD)
                cursor = cursor + 16'd1;
              dirty = 1'b1;
              ticks = '0;
            end
            default: ;
          endcase
          scratch[slot] = data;
        end
        lcdfb_pkg::OP_TICK: begin
          if (dirty) begin
            ticks = ticks + 9'd1;
            if (ticks >= lcdfb_pkg::REFRESH_DELAY) begin
              dirty         = 1'b0;
              ticks         = '0;
              r.refresh_req = 1'b1;
              tick_refreshes++;
            end
          end
        end
        default: ;
      endcase
      r.powered = powered;
      if (r.refresh_req)
        refreshes++;
      expected_words.push_back(r);
    endfunction

    function void check_word(logic [7:0] rd, logic rf, logic pw);
      lcd_result_t e;
      if (expected_words.size() == 0) begin
        $display("%0t: result word with none expected: read_data %02h refresh %b powered %b",
                 $time, rd, rf, pw);
        mismatches++;
        return;
      end
      e = expected_words.pop_front();
      words_checked++;
      if (rd !== e.rd_byte) begin
        $display("%0t: read_data expected %02h actual %02h", $time, e.rd_byte, rd);
        mismatches++;
      end
      if (rf !== e.refresh_req) begin
        $display("%0t: refresh expected %b actual %b", $time, e.refresh_req, rf);
        mismatches++;
      end
      if (pw !== e.powered) begin
        $display("%0t: display_powered expected %b actual %b", $time, e.powered, pw);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] operation = lcdfb_pkg::OP_READ;
  logic [7:0] address = 8'h00;
  logic [7:0] write_data = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] read_data;
  logic       refresh;
  logic       display_powered;

  lcd_reg_scoreboard board = new;
  int unsigned word_gap_pct = 0;
  int unsigned stall_pct = 0;
  int          quiet_cycles = 0;
  int          words_in = 0;

  always #4 clk = ~clk;

  mono_lcd_cursor_framebuffer_regs i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .operation       (operation),
    .address         (address),
    .write_data      (write_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .read_data       (read_data),
    .refresh         (refresh),
    .display_powered (display_powered)
  );

  // Note accepted words before checking results so the order never races.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready === 1'b1) begin
        board.note_word(operation, address, write_data);
        words_in++;
      end
      if (out_valid === 1'b1 && out_ready)
        board.check_word(read_data, refresh, display_powered);
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no word moved for %0d cycles", $time, quiet_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic push_word(input logic [1:0] op, input logic [7:0] addr,
                           input logic [7:0] data);
    while ($urandom_range(0, 99) < word_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    address    <= addr;
    write_data <= data;
    @(posedge clk);
    while (in_ready !== 1'b1)
      @(posedge clk);
  endtask

  task automatic push_random_word();
    int unsigned pick;
    logic [7:0]  b;
    logic [7:0]  m;
    pick = $urandom_range(0, 99);
    b    = 8'($urandom_range(0, 255));
    if (pick < 30)
      push_word(lcdfb_pkg::OP_WRITE, lcdfb_pkg::ADDR_DATA_WRITE, b);
    else if (pick < 37)
      // keep the cursor mostly inside the frame, sometimes far past it
      push_word(lcdfb_pkg::OP_WRITE, lcdfb_pkg::ADDR_CURSOR_HIGH,
                ($urandom_range(0, 3) == 0) ? b : 8'($urandom_range(0, 8'h25)));
    else if (pick < 42)
      push_word(lcdfb_pkg::OP_WRITE, lcdfb_pkg::ADDR_CURSOR_LOW, b);
    else if (pick < 48) begin
      case ($urandom_range(0, 3))
        0:       m = lcdfb_pkg::MODE_ROW_BACK;
        1:       m = lcdfb_pkg::MODE_FORWARD;
        2:       m = 8'h00;
        default: m = b;
      endcase
      push_word(lcdfb_pkg::OP_WRITE, lcdfb_pkg::ADDR_MODE, m);
    end else if (pick < 54)
      push_word(lcdfb_pkg::OP_WRITE, lcdfb_pkg::ADDR_POWER,
                ($urandom_range(0, 2) == 0) ? b : {7'd0, b[0]});
    else if (pick < 57)
      push_word(lcdfb_pkg::OP_WRITE, lcdfb_pkg::ADDR_POWER + 8'($urandom_range(1, 3)), b);
    else if (pick < 72)
      push_word(lcdfb_pkg::OP_READ, lcdfb_pkg::ADDR_DATA_READ, b);
    else if (pick < 82) begin
      case ($urandom_range(0, 4))
        0:       m = lcdfb_pkg::ADDR_STATUS;
        1:       m = lcdfb_pkg::ADDR_CURSOR_HIGH;
        2:       m = lcdfb_pkg::ADDR_CURSOR_LOW;
        3:       m = lcdfb_pkg::ADDR_MODE;
        default: m = 8'($urandom_range(0, 255));
      endcase
      push_word(lcdfb_pkg::OP_READ, m, b);
    end else if (pick < 90)
      push_word(lcdfb_pkg::OP_TICK, b, ~b);
    else if (pick < 95)
      push_word(lcdfb_pkg::OP_WRITE, 8'($urandom_range(0, 255)), b);
    else
      push_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), b);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: status, cursor wrap at both ends, both modes, power edges
    push_word(lcdfb_pkg::OP_READ,  lcdfb_pkg::ADDR_STATUS,      8'h00);
    push_word(lcdfb_pkg::OP_READ,  lcdfb_pkg::ADDR_DATA_READ,   8'h00);
    push_word(lcdfb_pkg::OP_WRITE, lcdfb_pkg::ADDR_CURSOR_HIGH, 8'hff);
    push_word(lcdfb_pkg::OP_WRITE, lcdfb_pkg::ADDR_CURSOR_LOW,  8'hff);
    push_word(lcdfb_pkg::OP_READ,  lcdfb_pkg::ADDR_CURSOR_HIGH, 8'h00);
    push_word(lcdfb_pkg::OP_WRITE, lcdfb_pkg::ADDR_MODE,        lcdfb_pkg::MODE_FORWARD);
    push_word(lcdfb_pkg::OP_WRITE, lcdfb_pkg::ADDR_DATA_WRITE,  8'ha5);
    push_word(lcdfb_pkg::OP_READ,  lcdfb_pkg::ADDR_DATA_READ,   8'h00);
    push_word(lcdfb_pkg::OP_WRITE, lcdfb_pkg::ADDR_MODE,        lcdfb_pkg::MODE_ROW_BACK);
    push_word(lcdfb_pkg::OP_WRITE, lcdfb_pkg::ADDR_DATA_WRITE,  8'h5a);
    push_word(lcdfb_pkg::OP_READ,  lcdfb_pkg::ADDR_CURSOR_LOW,  8'h00);
    push_word(lcdfb_pkg::OP_WRITE, lcdfb_pkg::ADDR_CURSOR_HIGH, 8'h25);
    push_word(lcdfb_pkg::OP_WRITE, lcdfb_pkg::ADDR_CURSOR_LOW,  8'h7f);
    push_word(lcdfb_pkg::OP_WRITE, lcdfb_pkg::ADDR_DATA_WRITE,  8'hff);
    push_word(lcdfb_pkg::OP_WRITE, lcdfb_pkg::ADDR_CURSOR_LOW,  8'h80);
    push_word(lcdfb_pkg::OP_READ,  lcdfb_pkg::ADDR_DATA_READ,   8'h00);
    push_word(lcdfb_pkg::OP_WRITE, lcdfb_pkg::ADDR_POWER,       8'h01);
    push_word(lcdfb_pkg::OP_WRITE, lcdfb_pkg::ADDR_POWER,       8'h01);
    push_word(lcdfb_pkg::OP_WRITE, lcdfb_pkg::ADDR_POWER + 8'd3, 8'h00);
    push_word(lcdfb_pkg::OP_WRITE, lcdfb_pkg::ADDR_POWER,       8'h00);
    push_word(lcdfb_pkg::OP_WRITE, lcdfb_pkg::ADDR_POWER + 8'd1, 8'h07);
    push_word(lcdfb_pkg::OP_WRITE, lcdfb_pkg::ADDR_POWER,       8'h00);
    push_word(OP_UNUSED,           8'hff,                       8'hff);
    push_word(lcdfb_pkg::OP_TICK,  8'h00,                       8'h00);
    push_word(lcdfb_pkg::OP_READ,  lcdfb_pkg::ADDR_MODE + 8'd1, 8'h00);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin word_gap_pct = 0;  stall_pct = 0;  end
        1:       begin word_gap_pct = 72; stall_pct = 0;  end
        2:       begin word_gap_pct = 0;  stall_pct = 72; end
        default: begin word_gap_pct = 26; stall_pct = 26; end
      endcase
      for (int n = 0; n < MIXED_PER_PHASE; n++)
        push_random_word();
      // uninterrupted tick run long enough to reach the timed refresh
      if (phase == 1) begin
        push_word(lcdfb_pkg::OP_WRITE, lcdfb_pkg::ADDR_DATA_WRITE,
                  8'($urandom_range(0, 255)));
        repeat (lcdfb_pkg::REFRESH_DELAY + 4)
          push_word(lcdfb_pkg::OP_TICK, 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
      end
    end
    in_valid <= 1'b0;

    while (board.expected_words.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Accepted %0d words and checked %0d results; %0d refreshes, %0d of them timed.",
             words_in, board.words_checked, board.refreshes, board.tick_refreshes);
    $display("Cursor beyond the frame redirected %0d data accesses to byte 0.",
             board.edge_accesses);
    if (board.mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
